// ===== design/pdbc_pkg.sv =====
// Package for the packet deframer with BSD checksum check.
// Holds the parser phase, the queue operation codes and the queue entry type.
// No dependencies; used by every module of the block.
package pdbc_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
    localparam logic [15:0] MAX_PAYLOAD_LENGTH_RESET = 16'd256;
    localparam int unsigned PADDR_WIDTH = 3;
    localparam logic REG_MAX_PAYLOAD_LENGTH = 1'b0;

    typedef enum logic [2:0] {
        PH_HDR0,
        PH_HDR1,
        PH_HDR2,
        PH_HDR3,
        PH_PAYLOAD
    } phase_t;

    typedef enum logic [1:0] {
        OP_PAYLOAD,
        OP_EMPTY,
        OP_LEN_ERROR
    } op_t;

    typedef struct packed {
        op_t         op;
        logic [7:0]  data;
        logic        first;
        logic        last;
        logic [15:0] rx_checksum;
    } entry_t;

endpackage

// ===== design/pdbc_front.sv =====
// Front end: parses the four header bytes and classifies every byte.
// Pushes one queue entry per result-producing byte. Depends on pdbc_pkg.
module pdbc_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic [7:0]          in_byte,
    input  logic                in_start,
    input  logic [15:0]         max_len,
    output logic                push,
    output pdbc_pkg::entry_t    push_entry
);

    pdbc_pkg::phase_t phase_reg, phase_next, phase_eff;
    logic [15:0] cksum_reg, cksum_next;
    logic [7:0]  len_lo_reg, len_lo_next;
    logic [15:0] left_reg, left_next;
    logic        discard_reg, discard_next;
    logic        first_reg, first_next;
    logic [15:0] len_full;
    logic [15:0] left_dec;
    logic        accept;

    assign accept   = in_valid && in_ready;
    assign len_full = {in_byte, len_lo_reg};
    assign left_dec = left_reg - 16'd1;
    assign phase_eff = in_start ? pdbc_pkg::PH_HDR0 : phase_reg;

    always_comb begin
        phase_next   = phase_reg;
        cksum_next   = cksum_reg;
        len_lo_next  = len_lo_reg;
        left_next    = left_reg;
        discard_next = discard_reg;
        first_next   = first_reg;
        if (accept) begin
            unique case (phase_eff)
                pdbc_pkg::PH_HDR1: begin
                    cksum_next = {in_byte, cksum_reg[7:0]};
                    phase_next = pdbc_pkg::PH_HDR2;
                end
                pdbc_pkg::PH_HDR2: begin
                    len_lo_next = in_byte;
                    phase_next  = pdbc_pkg::PH_HDR3;
                end
                pdbc_pkg::PH_HDR3: begin
                    left_next  = len_full;
                    first_next = 1'b1;
                    if (len_full == 16'd0) begin
                        phase_next = pdbc_pkg::PH_HDR0;
                    end else begin
                        phase_next   = pdbc_pkg::PH_PAYLOAD;
                        discard_next = (len_full > max_len);
                    end
                end
                pdbc_pkg::PH_PAYLOAD: begin
                    left_next = left_dec;
                    if (!discard_reg) begin
                        first_next = 1'b0;
                    end
                    if (left_dec == 16'd0) begin
                        phase_next   = pdbc_pkg::PH_HDR0;
                        discard_next = 1'b0;
                    end
                end
                default: begin
                    cksum_next   = {8'd0, in_byte};
                    discard_next = 1'b0;
                    phase_next   = pdbc_pkg::PH_HDR1;
                end
            endcase
        end
    end

    always_comb begin
        push                   = 1'b0;
        push_entry.op          = pdbc_pkg::OP_PAYLOAD;
        push_entry.data        = 8'd0;
        push_entry.first       = first_reg;
        push_entry.last        = 1'b1;
        push_entry.rx_checksum = cksum_reg;
        if (accept) begin
            unique case (phase_eff)
                pdbc_pkg::PH_HDR3: begin
                    if (len_full == 16'd0) begin
                        push          = 1'b1;
                        push_entry.op = pdbc_pkg::OP_EMPTY;
                    end else if (len_full > max_len) begin
                        push          = 1'b1;
                        push_entry.op = pdbc_pkg::OP_LEN_ERROR;
                    end
                end
                pdbc_pkg::PH_PAYLOAD: begin
                    push            = !discard_reg;
                    push_entry.data = in_byte;
                    push_entry.last = (left_dec == 16'd0);
                end
                default: begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= pdbc_pkg::PH_HDR0;
            cksum_reg   <= 16'd0;
            len_lo_reg  <= 8'd0;
            left_reg    <= 16'd0;
            discard_reg <= 1'b0;
            first_reg   <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cksum_reg   <= cksum_next;
            len_lo_reg  <= len_lo_next;
            left_reg    <= left_next;
            discard_reg <= discard_next;
            first_reg   <= first_next;
        end
    end

endmodule

// ===== design/pdbc_queue.sv =====
// Short queue of classified transactions between front end and back end.
// Register-based circular buffer with a fill count. Depends on pdbc_pkg.
module pdbc_queue #(
    parameter int unsigned DEPTH = pdbc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  pdbc_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              not_full,
    output logic              not_empty,
    output pdbc_pkg::entry_t  head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    pdbc_pkg::entry_t  slots [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign not_full  = (count_reg != CNT_FULL);
    assign not_empty = (count_reg != '0);
    assign head      = slots[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("Queue count exceeds its depth.");

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (not_full || pop))
        else $error("Queue written while full.");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> not_empty)
        else $error("Queue read while empty.");

    a_count_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("Queue count did not follow a write.");
`endif

endmodule

// ===== design/pdbc_back.sv =====
// Back end: runs the BSD rotate-and-add checksum over payload bytes and
// holds each result in an output register. Depends on pdbc_pkg.
module pdbc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  pdbc_pkg::entry_t  q_head,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_data,
    output logic              out_last,
    output logic              out_empty,
    output logic              out_ok,
    output logic              out_len_error
);

    logic [15:0] sum_reg, sum_next;
    logic [15:0] sum_base, sum_new;
    logic        valid_reg;
    logic [7:0]  data_reg, data_next;
    logic        last_reg, last_next;
    logic        empty_reg, empty_next;
    logic        ok_reg, ok_next;
    logic        err_reg, err_next;

    assign pop      = q_valid && (!valid_reg || out_ready);
    assign sum_base = q_head.first ? 16'd0 : sum_reg;
    assign sum_new  = {sum_base[0], sum_base[15:1]} + {8'd0, q_head.data};

    always_comb begin
        sum_next   = sum_reg;
        data_next  = 8'd0;
        last_next  = 1'b1;
        empty_next = 1'b0;
        ok_next    = 1'b0;
        err_next   = 1'b0;
        case (q_head.op)
            pdbc_pkg::OP_PAYLOAD: begin
                if (pop) begin
                    sum_next = sum_new;
                end
                data_next = q_head.data;
                last_next = q_head.last;
                ok_next   = q_head.last && (sum_new == q_head.rx_checksum);
            end
            pdbc_pkg::OP_EMPTY: begin
                empty_next = 1'b1;
                ok_next    = (q_head.rx_checksum == 16'd0);
            end
            default: begin
                err_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            data_reg  <= data_next;
            last_reg  <= last_next;
            empty_reg <= empty_next;
            ok_reg    <= ok_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            sum_reg   <= 16'd0;
        end else begin
            sum_reg <= sum_next;
            if (pop) begin
                valid_reg <= 1'b1;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = valid_reg;
    assign out_data      = data_reg;
    assign out_last      = last_reg;
    assign out_empty     = empty_reg;
    assign out_ok        = ok_reg;
    assign out_len_error = err_reg;

`ifndef NO_ASSERTIONS
    a_flags_exclusive: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !(empty_reg && err_reg))
        else $error("Result flagged both empty and length error.");

    a_ok_only_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && ok_reg) |-> (last_reg && !err_reg))
        else $error("Checksum match flagged on a result that is not last.");

    a_sum_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !pop |=> (sum_reg == $past(sum_reg)))
        else $error("Running checksum changed without a payload transaction.");
`endif

endmodule

// ===== design/packet_deframer_bsd_checksum.sv =====
// Top level of the packet deframer with BSD 16-bit checksum check.
// Holds the configuration register and connects front end, queue and back end.
// Depends on pdbc_pkg, pdbc_front, pdbc_queue and pdbc_back.
//
// The block takes one packet byte per cycle while the queue is not full.
// Each packet starts with a four-byte little-endian header (checksum, then
// length); every payload byte is passed on, and the last one reports whether
// the rotate-and-add checksum matches. A zero length gives one empty result
// and a length above max_payload_length (APB address 0, reset 256) gives one
// error result, after which that payload is dropped. A result is registered
// twice: the front end writes it into the queue when its byte is accepted,
// and the back end loads it into its output register when it pops the entry.
// The queue of QUEUE_DEPTH transactions lets input continue while a result
// waits, and s_ready drops only when that queue is full.
module packet_deframer_bsd_checksum #(
    parameter int unsigned QUEUE_DEPTH = pdbc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [7:0]                         s_rx_byte,
    input  logic                               s_packet_start,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [7:0]                         m_payload_byte,
    output logic                               m_last_of_packet,
    output logic                               m_empty_payload,
    output logic                               m_checksum_ok,
    output logic                               m_length_error,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pdbc_pkg::PADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [15:0]      max_len_reg;
    logic             cfg_write;
    logic             push;
    logic             pop;
    logic             q_not_full;
    logic             q_not_empty;
    pdbc_pkg::entry_t push_entry;
    pdbc_pkg::entry_t q_head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == pdbc_pkg::REG_MAX_PAYLOAD_LENGTH) ?
                       {16'd0, max_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_len_reg <= pdbc_pkg::MAX_PAYLOAD_LENGTH_RESET;
        end else if (cfg_write && (paddr[2] == pdbc_pkg::REG_MAX_PAYLOAD_LENGTH)) begin
            max_len_reg <= pwdata[15:0];
        end
    end

    assign s_ready = q_not_full;

    pdbc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_valid),
        .in_ready   (q_not_full),
        .in_byte    (s_rx_byte),
        .in_start   (s_packet_start),
        .max_len    (max_len_reg),
        .push       (push),
        .push_entry (push_entry)
    );

    pdbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .not_full   (q_not_full),
        .not_empty  (q_not_empty),
        .head       (q_head)
    );

    pdbc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_not_empty),
        .q_head        (q_head),
        .pop           (pop),
        .out_valid     (m_valid),
        .out_ready     (m_ready),
        .out_data      (m_payload_byte),
        .out_last      (m_last_of_packet),
        .out_empty     (m_empty_payload),
        .out_ok        (m_checksum_ok),
        .out_len_error (m_length_error)
    );

endmodule

// ===== tb/packet_deframer_bsd_checksum_tb.sv =====
// Testbench for packet_deframer_bsd_checksum: streams packet bytes, predicts each result
// with a local deframer and checksum model, and checks every result field by field.
// Depends on pdbc_pkg and the packet_deframer_bsd_checksum top level.
module packet_deframer_bsd_checksum_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned STALL_LIMIT = 4000;
    localparam int unsigned DRAIN_CYCLES = 6;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       empty;
        logic       ok;
        logic       err;
    } frame_result_t;

    // Directed packets: {packet_start, byte}.
    localparam logic [8:0] DIRECTED_BYTES [25] = '{
        9'h100, 9'h000, 9'h000, 9'h000,
        9'h0FF, 9'h000, 9'h001, 9'h000, 9'h0FF,
        9'h000, 9'h000, 9'h001, 9'h001,
        9'h1AA, 9'h055, 9'h002, 9'h000, 9'h080, 9'h07F,
        9'h012, 9'h034,
        9'h134, 9'h012, 9'h000, 9'h000
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_packet_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_payload_byte;
    logic        m_last_of_packet;
    logic        m_empty_payload;
    logic        m_checksum_ok;
    logic        m_length_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [pdbc_pkg::PADDR_WIDTH-1:0] paddr = '0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    rx_item_t      pending_bytes[$];
    frame_result_t expected_results[$];
    int unsigned   error_count = 0;
    int unsigned   stall_cycles = 0;
    bit            calm = 1'b0;

    // Local copy of the deframer state.
    pdbc_pkg::phase_t parse_ph = pdbc_pkg::PH_HDR0;
    logic [15:0] hdr_checksum = '0;
    logic [15:0] hdr_length = '0;
    logic [15:0] remaining = '0;
    logic [15:0] bsd_sum = '0;
    logic        dropping = 1'b0;
    logic [15:0] max_len_cfg = pdbc_pkg::MAX_PAYLOAD_LENGTH_RESET;

    packet_deframer_bsd_checksum u_top (.*);

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want) begin
            report_mismatch(name, got, want);
        end
    endtask

    task automatic predict_frame_byte(input logic [7:0] b, input logic start);
        if (start) begin
            parse_ph = pdbc_pkg::PH_HDR0;
        end
        case (parse_ph)
            pdbc_pkg::PH_HDR0: begin
                hdr_checksum = {8'h00, b};
                dropping = 1'b0;
                parse_ph = pdbc_pkg::PH_HDR1;
            end
            pdbc_pkg::PH_HDR1: begin
                hdr_checksum[15:8] = b;
                parse_ph = pdbc_pkg::PH_HDR2;
            end
            pdbc_pkg::PH_HDR2: begin
                hdr_length = {8'h00, b};
                parse_ph = pdbc_pkg::PH_HDR3;
            end
            pdbc_pkg::PH_HDR3: begin
                hdr_length[15:8] = b;
                bsd_sum = '0;
                remaining = hdr_length;
                if (hdr_length == 16'h0) begin
                    parse_ph = pdbc_pkg::PH_HDR0;
                    expected_results.push_back({8'h00, 1'b1, 1'b1, hdr_checksum == 16'h0,
                                                1'b0});
                end else begin
                    parse_ph = pdbc_pkg::PH_PAYLOAD;
                    dropping = hdr_length > max_len_cfg;
                    if (dropping) begin
                        expected_results.push_back({8'h00, 1'b1, 1'b0, 1'b0, 1'b1});
                    end
                end
            end
            default: begin
                remaining = remaining - 16'd1;
                if (dropping) begin
                    if (remaining == 16'h0) begin
                        dropping = 1'b0;
                        parse_ph = pdbc_pkg::PH_HDR0;
                    end
                end else begin
                    bsd_sum = {bsd_sum[0], bsd_sum[15:1]} + {8'h00, b};
                    if (remaining == 16'h0) begin
                        parse_ph = pdbc_pkg::PH_HDR0;
                        expected_results.push_back({b, 1'b1, 1'b0, bsd_sum == hdr_checksum,
                                                    1'b0});
                    end else begin
                        expected_results.push_back({b, 1'b0, 1'b0, 1'b0, 1'b0});
                    end
                end
            end
        endcase
    endtask

    task automatic push_byte(input logic [7:0] b, input logic start);
        pending_bytes.push_back({b, start});
    endtask

    task automatic add_packet(input logic [15:0] len, input bit good_sum, input logic start,
                              input int unsigned cut);
        logic [7:0]  pkt[$];
        logic [15:0] sum;
        logic [15:0] hdr_sum;
        int unsigned i;
        sum = '0;
        pkt = {};
        for (i = 0; i < len; i++) begin
            pkt.push_back(8'($urandom_range(0, 255)));
            sum = {sum[0], sum[15:1]} + {8'h00, pkt[i]};
        end
        hdr_sum = good_sum ? sum : 16'($urandom_range(0, 65535));
        pkt.push_front(len[15:8]);
        pkt.push_front(len[7:0]);
        pkt.push_front(hdr_sum[15:8]);
        pkt.push_front(hdr_sum[7:0]);
        for (i = 0; i < cut && i < pkt.size(); i++) begin
            push_byte(pkt[i], (i == 0) ? start : 1'b0);
        end
    endtask

    task automatic gen_random(input int unsigned n);
        int unsigned added;
        int unsigned r;
        int unsigned len;
        int unsigned cut;
        bit          dirty;
        bit          truncated;
        added = 0;
        dirty = 1'b1;
        while (added < n) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                cut = $urandom_range(1, 6);
                repeat (cut) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
                dirty = 1'b1;
                added += cut;
            end else begin
                truncated = r < 16;
                if (truncated) begin
                    len = $urandom_range(1, 10);
                end else if (r < 30 && max_len_cfg <= 64) begin
                    len = max_len_cfg + 1 + $urandom_range(0, 6);
                end else if (r < 40) begin
                    len = 0;
                end else if (r < 45) begin
                    len = $urandom_range(11, 40);
                end else begin
                    len = $urandom_range(1, 10);
                end
                cut = truncated ? $urandom_range(1, len + 3) : len + 4;
                add_packet(16'(len), 1'($urandom_range(0, 1)),
                           dirty | 1'($urandom_range(0, 1)), cut);
                added += cut;
                dirty = truncated;
            end
        end
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_max_len(input logic [15:0] value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= pdbc_pkg::PADDR_WIDTH'(4 * pdbc_pkg::REG_MAX_PAYLOAD_LENGTH);
        pwdata <= {16'h0000, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        max_len_cfg = value;
    endtask

    always @(posedge aclk) begin
        rx_item_t item;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                predict_frame_byte(s_rx_byte, s_packet_start);
            end
            if (!s_valid || s_ready) begin
                if (pending_bytes.size() != 0 && (calm || $urandom_range(0, 99) >= 29)) begin
                    item = pending_bytes.pop_front();
                    s_valid <= 1'b1;
                    s_rx_byte <= item.data;
                    s_packet_start <= item.start;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        frame_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected transaction", m_payload_byte, 8'h00);
                end else begin
                    want = expected_results.pop_front();
                    check_field("payload_byte", m_payload_byte, want.data);
                    check_field("last_of_packet", 8'(m_last_of_packet), 8'(want.last));
                    check_field("empty_payload", 8'(m_empty_payload), 8'(want.empty));
                    check_field("checksum_ok", 8'(m_checksum_ok), 8'(want.ok));
                    check_field("length_error", 8'(m_length_error), 8'(want.err));
                end
            end
            m_ready <= calm || $urandom_range(0, 99) >= 29;
        end
    end

    always @(posedge aclk) begin
        if (pending_bytes.size() != 0 || s_valid || expected_results.size() != 0) begin
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stall_cycles = 0;
            end else begin
                stall_cycles++;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end else begin
            stall_cycles = 0;
        end
    end

    initial begin
        int unsigned i;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < 25; i++) begin
            push_byte(DIRECTED_BYTES[i][7:0], DIRECTED_BYTES[i][8]);
        end
        wait_drained();

        gen_random(20);
        wait_drained();
        gen_random(15);
        wait_drained();

        write_max_len(16'd0);
        gen_random(25);
        wait_drained();

        write_max_len(16'hFFFF);
        calm = 1'b1;
        add_packet(16'd259, 1'b1, 1'b1, 263);
        gen_random(10);
        wait_drained();
        calm = 1'b0;

        write_max_len(16'd5);
        gen_random(20);
        wait_drained();

        write_max_len(16'd12);
        gen_random(20);
        wait_drained();

        while (expected_results.size() != 0) begin
            void'(expected_results.pop_front());
            report_mismatch("missing transaction", 8'h00, 8'h00);
        end
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== packet_deframer_bsd_checksum.f =====
design/pdbc_pkg.sv
design/pdbc_front.sv
design/pdbc_queue.sv
design/pdbc_back.sv
design/packet_deframer_bsd_checksum.sv
tb/packet_deframer_bsd_checksum_tb.sv
